// ===== sv/efrc_pkg.sv =====
// Shared types, constants and the byte-wide CRC-32 function for the
// Ethernet frame receive checker. No dependencies.
package efrc_pkg;

   localparam int COUNT_WIDTH_DEFAULT = 14;
   localparam int PLEN_W = 14;
   localparam int PLEN_MAX = (1 << PLEN_W) - 1;
   localparam int DST_END = 6;
   localparam int SRC_END = 12;
   localparam int HDR_LEN = 14;
   localparam int FCS_LEN = 4;
   localparam int MIN_FRAME = HDR_LEN + FCS_LEN;

   localparam logic [31:0] CRC_POLY = 32'hEDB8_8320;
   localparam logic [31:0] CRC_INIT = 32'hFFFF_FFFF;

   localparam logic [15:0] ETYPE_IPV4 = 16'h0800;
   localparam logic [15:0] ETYPE_ARP = 16'h0806;
   localparam logic [15:0] ETYPE_IPV6 = 16'h86DD;

   localparam logic [PLEN_W-1:0] MAX_PAYLOAD_RESET = PLEN_W'(1500);

   localparam int CSR_ADDR_W = 3;
   localparam logic CSR_IDX_MAX_PAYLOAD = 1'b0;

   typedef enum logic [1:0] {
      CLASS_IPV4,
      CLASS_ARP,
      CLASS_IPV6,
      CLASS_OTHER
   } type_class_type;

   typedef enum logic [1:0] {
      STATUS_OK,
      STATUS_SHORT,
      STATUS_OVERSIZE
   } frame_status_type;

   typedef struct packed {
      logic       en;
      logic [7:0] data;
      logic       last;
   } step_type;

   typedef struct packed {
      logic [47:0]       dst_mac;
      logic [47:0]       src_mac;
      logic [15:0]       eth_type;
      type_class_type    type_class;
      logic [PLEN_W-1:0] payload_bytes;
      logic [31:0]       fcs_stored;
      logic [31:0]       fcs_computed;
      logic              crc_ok;
      frame_status_type  frame_status;
   } result_type;

   // reflected CRC-32, one byte, LSB first
   function automatic logic [31:0] crc_byte(input logic [31:0] crc, input logic [7:0] b);
      logic [31:0] c;
      c = crc ^ {24'h0, b};
      for (int k = 0; k < 8; k++) begin
         c = c[0] ? ((c >> 1) ^ CRC_POLY) : (c >> 1);
      end
      return c;
   endfunction

endpackage

// ===== sv/efrc_core.sv =====
// Per-frame state of the checker: header capture, FCS delay line, CRC and
// byte count, plus the result built on the final word. Uses efrc_pkg.
module efrc_core
   import efrc_pkg::*;
#(
   parameter int COUNT_WIDTH = COUNT_WIDTH_DEFAULT
) (
   input  logic              clock,
   input  logic              reset,
   input  step_type          step,
   input  logic [PLEN_W-1:0] max_payload,
   output result_type        result
);

   localparam int LenWidth = (COUNT_WIDTH > PLEN_W) ? COUNT_WIDTH : PLEN_W;
   localparam logic [COUNT_WIDTH-1:0] CountMax = {COUNT_WIDTH{1'b1}};

   logic [COUNT_WIDTH-1:0] count_ff, count_in;
   logic [31:0]            crc_ff, crc_in;
   logic [7:0]             tail_ff [FCS_LEN];
   logic [7:0]             tail_in [FCS_LEN];
   logic [47:0]            dst_ff, dst_in;
   logic [47:0]            src_ff, src_in;
   logic [15:0]            type_ff, type_in;

   logic [LenWidth-1:0]    plen_wide;
   logic                   short_frame;

   always_comb begin
      dst_in = dst_ff;
      src_in = src_ff;
      type_in = type_ff;
      if (count_ff < COUNT_WIDTH'(DST_END)) begin
         dst_in = {dst_ff[39:0], step.data};
      end else if (count_ff < COUNT_WIDTH'(SRC_END)) begin
         src_in = {src_ff[39:0], step.data};
      end else if (count_ff < COUNT_WIDTH'(HDR_LEN)) begin
         type_in = {type_ff[7:0], step.data};
      end
      crc_in = (count_ff >= COUNT_WIDTH'(FCS_LEN)) ?
               crc_byte(crc_ff, tail_ff[FCS_LEN-1]) : crc_ff;
      tail_in[0] = step.data;
      for (int i = 1; i < FCS_LEN; i++) begin
         tail_in[i] = tail_ff[i-1];
      end
      count_in = (count_ff == CountMax) ? count_ff : count_ff + 1'b1;
   end

   always_comb begin
      short_frame = count_in < COUNT_WIDTH'(MIN_FRAME);
      plen_wide = LenWidth'(count_in) - LenWidth'(MIN_FRAME);
      result.dst_mac = dst_in;
      result.src_mac = src_in;
      result.eth_type = type_in;
      case (type_in)
         ETYPE_IPV4: result.type_class = CLASS_IPV4;
         ETYPE_ARP:  result.type_class = CLASS_ARP;
         ETYPE_IPV6: result.type_class = CLASS_IPV6;
         default:    result.type_class = CLASS_OTHER;
      endcase
      if (short_frame) begin
         result.payload_bytes = '0;
         result.fcs_stored = '0;
         result.fcs_computed = '0;
         result.crc_ok = 1'b0;
         result.frame_status = STATUS_SHORT;
      end else begin
         result.payload_bytes = (plen_wide > LenWidth'(PLEN_MAX)) ?
                                PLEN_W'(PLEN_MAX) : plen_wide[PLEN_W-1:0];
         result.fcs_stored = {tail_in[0], tail_in[1], tail_in[2], tail_in[3]};
         result.fcs_computed = ~crc_in;
         result.crc_ok = result.fcs_stored == result.fcs_computed;
         result.frame_status = (result.payload_bytes > max_payload) ?
                               STATUS_OVERSIZE : STATUS_OK;
      end
   end

   always_ff @(posedge clock) begin
      if (reset || (step.en && step.last)) begin
         count_ff <= '0;
         crc_ff <= CRC_INIT;
         for (int i = 0; i < FCS_LEN; i++) begin
            tail_ff[i] <= '0;
         end
         dst_ff <= '0;
         src_ff <= '0;
         type_ff <= '0;
      end else if (step.en) begin
         count_ff <= count_in;
         crc_ff <= crc_in;
         tail_ff <= tail_in;
         dst_ff <= dst_in;
         src_ff <= src_in;
         type_ff <= type_in;
      end
   end

endmodule

// ===== sv/ethernet_frame_rx_checker.sv =====
// Top level of the Ethernet frame receive checker: input word register,
// result register, APB register port. Uses efrc_pkg and efrc_core.
//
// One frame byte is taken per word, one word per cycle, sustained, with the
// final byte flagged; the FCS check result for that frame is valid on the
// result channel once the final byte has passed the input register and the
// result register. The clock period is set by the byte-wide CRC-32 update
// and the length compare that sit between the input register and the result
// register. A waiting result does not block intake of the next frame; input
// stalls only when a second final byte meets a result that is still stalled.
// The single register, max_payload, is at byte address 0 and resets to 1500.
module ethernet_frame_rx_checker
   import efrc_pkg::*;
#(
   parameter int COUNT_WIDTH = COUNT_WIDTH_DEFAULT
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_valid,
   output logic                  req_stall,
   input  logic [7:0]            req_data_byte,
   input  logic                  req_last_byte,
   output logic                  rsp_valid,
   input  logic                  rsp_stall,
   output logic [47:0]           rsp_dst_mac,
   output logic [47:0]           rsp_src_mac,
   output logic [15:0]           rsp_eth_type,
   output logic [1:0]            rsp_type_class,
   output logic [PLEN_W-1:0]     rsp_payload_bytes,
   output logic [31:0]           rsp_fcs_stored,
   output logic [31:0]           rsp_fcs_computed,
   output logic                  rsp_crc_ok,
   output logic [1:0]            rsp_frame_status,
   input  logic                  psel,
   input  logic                  penable,
   input  logic                  pwrite,
   input  logic [CSR_ADDR_W-1:0] paddr,
   input  logic [31:0]           pwdata,
   output logic [31:0]           prdata,
   output logic                  pready
);

   logic              in_valid_ff, in_valid_in;
   logic [7:0]        in_data_ff;
   logic              in_last_ff;
   logic              out_valid_ff, out_valid_in;
   result_type        out_ff;
   result_type        result;
   step_type          step;
   logic              advance;
   logic              accept;
   logic [PLEN_W-1:0] max_payload_ff;

   assign advance = in_valid_ff && (!in_last_ff || !out_valid_ff || !rsp_stall);
   assign req_stall = in_valid_ff && !advance;
   assign accept = req_valid && !req_stall;
   assign in_valid_in = accept || (in_valid_ff && !advance);
   assign out_valid_in = (advance && in_last_ff) || (out_valid_ff && rsp_stall);

   assign step.en = advance;
   assign step.data = in_data_ff;
   assign step.last = in_last_ff;

   efrc_core #(
      .COUNT_WIDTH(COUNT_WIDTH)
   ) u_core (
      .clock(clock),
      .reset(reset),
      .step(step),
      .max_payload(max_payload_ff),
      .result(result)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff <= 1'b0;
         out_valid_ff <= 1'b0;
      end else begin
         in_valid_ff <= in_valid_in;
         out_valid_ff <= out_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         in_data_ff <= req_data_byte;
         in_last_ff <= req_last_byte;
      end
      if (advance && in_last_ff) begin
         out_ff <= result;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         max_payload_ff <= MAX_PAYLOAD_RESET;
      end else if (psel && penable && pwrite && paddr[2] == CSR_IDX_MAX_PAYLOAD) begin
         max_payload_ff <= pwdata[PLEN_W-1:0];
      end
   end

   assign pready = 1'b1;
   assign prdata = (paddr[2] == CSR_IDX_MAX_PAYLOAD) ? 32'(max_payload_ff) : '0;

   assign rsp_valid = out_valid_ff;
   assign rsp_dst_mac = out_ff.dst_mac;
   assign rsp_src_mac = out_ff.src_mac;
   assign rsp_eth_type = out_ff.eth_type;
   assign rsp_type_class = out_ff.type_class;
   assign rsp_payload_bytes = out_ff.payload_bytes;
   assign rsp_fcs_stored = out_ff.fcs_stored;
   assign rsp_fcs_computed = out_ff.fcs_computed;
   assign rsp_crc_ok = out_ff.crc_ok;
   assign rsp_frame_status = out_ff.frame_status;

   a_stall_cause: assert property (@(posedge clock) disable iff (reset)
      req_stall |-> in_valid_ff && in_last_ff && out_valid_ff && rsp_stall)
      else $error("input stalled without a blocked result");

   a_crc_ok_match: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_crc_ok |-> rsp_fcs_stored == rsp_fcs_computed)
      else $error("crc_ok set on mismatching FCS");

   a_short_clean: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_frame_status == STATUS_SHORT |->
         rsp_payload_bytes == '0 && !rsp_crc_ok && rsp_fcs_computed == '0)
      else $error("short frame with nonzero length or CRC fields");

   a_result_load: assert property (@(posedge clock) disable iff (reset)
      advance && in_last_ff |=> rsp_valid)
      else $error("final word did not produce a result");

   a_mtu_reset: assert property (@(posedge clock)
      $past(reset) |-> max_payload_ff == MAX_PAYLOAD_RESET)
      else $error("max_payload not at reset value");

endmodule
